// File: src/mass_bounded_combination_enumerator_unit_macros.svh
// Assertion helpers for the combination enumerator.
// Used at the end of the top level; needs clk and rst in scope.
`ifndef MASS_BOUNDED_COMBINATION_ENUMERATOR_UNIT_MACROS_SVH
`define MASS_BOUNDED_COMBINATION_ENUMERATOR_UNIT_MACROS_SVH

// Same-cycle implication, held off during reset
`define MBCE_ASSERT_IMM(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mbce: same-cycle check failed");

// Next-cycle implication, held off during reset
`define MBCE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mbce: next-cycle check failed");

`endif

// File: src/mbce_pkg.sv
// Shared types and constants of the combination enumerator.
// Used by mbce_ctrl, mbce_datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mbce_pkg;

  localparam int MASS_W       = 32;
  localparam int COUNT_W      = 4;
  localparam int FUNC_W       = 2;
  localparam int INDEX_W      = 6;
  localparam int SLOT_POS_W   = 3;
  localparam int SLOT_VALUE_W = 7;
  localparam int CFG_INDEX_W  = 2;
  localparam int CFG_DATA_W   = 32;

  // Input function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_TYPE_COUNT   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_COMBINATION_LENGTH = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CUMULATIVE_BOUND   = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PRECURSOR_BOUND    = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [INDEX_W-1:0] block_index;
    logic [MASS_W-1:0]  block_mass;
    logic [COUNT_W-1:0] block_limit;
  } in_item_t;

  typedef struct packed {
    logic                    found;
    logic [MASS_W-1:0]       combination_mass;
    logic [SLOT_POS_W-1:0]   slot_position;
    logic [SLOT_VALUE_W-1:0] slot_value;
    logic                    last;
  } out_item_t;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_START,
    OP_SWRD,
    OP_SWACC,
    OP_LDX,
    OP_RD,
    OP_DEC,
    OP_INC,
    OP_BUMPW,
    OP_BUMPX,
    OP_SATW,
    OP_VW,
    OP_PREV,
    OP_PINC,
    OP_JP,
    OP_JDEC,
    OP_FOUND1,
    OP_FOUND0,
    OP_KINC
  } op_t;

  // Slot pointer selection
  typedef enum logic [2:0] {
    SEL_P,
    SEL_P1,
    SEL_J,
    SEL_J1,
    SEL_K
  } sel_t;

  typedef struct packed {
    op_t  op;
    sel_t sel;
  } cmd_t;

  typedef struct packed {
    logic sv_le_nb;
    logic over;
    logic lh;
    logic rf;
    logic slot0_gt;
    logic p_lt_last;
    logic p_lt_len;
    logic cmp_prev;
    logic j_zero;
    logic sweep_done;
    logic k_last;
  } status_t;

endpackage
`default_nettype wire

// File: src/mbce_datapath.sv
// Datapath of the combination enumerator: slots, block memories, use counts,
// running mass and configuration registers. Depends on mbce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbce_datapath #(
  parameter int MAX_BLOCK_TYPES = 64,
  parameter int MAX_SLOTS       = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mbce_pkg::cmd_t                      cmd,
  input  mbce_pkg::in_item_t                  in_item,
  input  logic                                cfg_we,
  input  logic [mbce_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [mbce_pkg::CFG_DATA_W-1:0]     cfg_data,
  output mbce_pkg::status_t                   status,
  output mbce_pkg::out_item_t                 out_item
);
  import mbce_pkg::*;

  localparam int SW  = $clog2(MAX_BLOCK_TYPES + 2);
  localparam int AW  = $clog2(MAX_BLOCK_TYPES);
  localparam int CW  = $clog2(MAX_BLOCK_TYPES + 1);
  localparam int PW  = $clog2(MAX_SLOTS + 1);
  localparam int SIW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int MW  = MASS_W + COUNT_W + AW;

  // Configuration registers
  logic [6:0]        n_cfg;
  logic [3:0]        len_cfg;
  logic [MASS_W-1:0] cum_bound;
  logic [MASS_W-1:0] pre_bound;

  // Working registers
  logic [SW-1:0] nb;
  logic [PW-1:0] slen;
  logic [SW-1:0] slot [MAX_SLOTS];
  logic [SW-1:0] x;
  logic [SW-1:0] prev;
  logic [PW-1:0] p;
  logic [PW-1:0] j;
  logic [PW-1:0] k;
  logic [CW-1:0] swk;
  logic [MW-1:0] s_mass;
  logic          found;

  // Block stores and use counts
  logic [MASS_W-1:0]          mass_mem [MAX_BLOCK_TYPES];
  logic [COUNT_W-1:0]         lim_mem  [MAX_BLOCK_TYPES];
  logic [COUNT_W-1:0]         cnt_mem  [MAX_BLOCK_TYPES];
  logic [MAX_BLOCK_TYPES-1:0] cnt_vld;

  // Registered read data
  logic [MASS_W-1:0]  mass_q;
  logic [COUNT_W-1:0] lim_q;
  logic [COUNT_W-1:0] cnt_q;
  logic               vld_q;
  logic               rng_q;

  logic [SW-1:0]              n_sat;
  logic [PW-1:0]              len_sat;
  logic [PW-1:0]              sidx;
  logic [SW-1:0]              sv;
  logic [SW-1:0]              xm1;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic                       x_rng;
  logic [SW-1:0]              bx;
  logic [COUNT_W-1:0]         cnt_eff;
  logic [MASS_W+COUNT_W-1:0]  prod;
  logic [MW-1:0]              m1;
  logic [MW-1:0]              m15;
  logic                       load_ok;

  // Clamp the configured sizes into range
  always_comb begin
    if (n_cfg == '0) begin
      n_sat = SW'(1);
    end else if (int'(n_cfg) > MAX_BLOCK_TYPES) begin
      n_sat = SW'(MAX_BLOCK_TYPES);
    end else begin
      n_sat = SW'(n_cfg);
    end
    if (len_cfg == '0) begin
      len_sat = PW'(1);
    end else if (int'(len_cfg) > MAX_SLOTS) begin
      len_sat = PW'(MAX_SLOTS);
    end else begin
      len_sat = PW'(len_cfg);
    end
  end

  // Select the slot pointer and read the slot
  always_comb begin
    case (cmd.sel)
      SEL_P:   sidx = p;
      SEL_P1:  sidx = p + PW'(1);
      SEL_J:   sidx = j;
      SEL_J1:  sidx = j - PW'(1);
      SEL_K:   sidx = k;
      default: sidx = p;
    endcase
    sv = (int'(sidx) < MAX_SLOTS) ? slot[sidx[SIW-1:0]] : '0;
  end

  assign xm1     = x - SW'(1);
  assign rd_addr = (cmd.op == OP_SWRD) ? swk[AW-1:0] : xm1[AW-1:0];
  assign wr_addr = xm1[AW-1:0];
  assign x_rng   = (x != '0) && (x <= nb);
  assign bx      = (x >= nb) ? nb + SW'(1) : x + SW'(1);
  assign cnt_eff = vld_q ? cnt_q : '0;
  assign prod    = (MASS_W+COUNT_W)'(cnt_eff) * (MASS_W+COUNT_W)'(mass_q);
  assign m1      = MW'(mass_q);
  assign m15     = (m1 << 4) - m1;
  assign load_ok = int'(in_item.block_index) < MAX_BLOCK_TYPES;

  // Memories: block stores written by loads, counts by the sequencer
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && load_ok) begin
      mass_mem[AW'(in_item.block_index)] <= in_item.block_mass;
      lim_mem[AW'(in_item.block_index)]  <= in_item.block_limit;
    end
    if ((cmd.op == OP_DEC || cmd.op == OP_INC) && rng_q) begin
      cnt_mem[wr_addr] <= (cmd.op == OP_INC) ? cnt_eff + COUNT_W'(1)
                                             : cnt_eff - COUNT_W'(1);
    end
    if (cmd.op == OP_RD || cmd.op == OP_SWRD) begin
      mass_q <= mass_mem[rd_addr];
      lim_q  <= lim_mem[rd_addr];
      cnt_q  <= cnt_mem[rd_addr];
      vld_q  <= cnt_vld[rd_addr];
      rng_q  <= (cmd.op == OP_SWRD) || x_rng;
    end
  end

  // Configuration, slots, counters and running mass
  always_ff @(posedge clk) begin
    if (rst) begin
      n_cfg     <= 7'd1;
      len_cfg   <= 4'd1;
      cum_bound <= '0;
      pre_bound <= '0;
      cnt_vld   <= '0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        slot[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_BLOCK_TYPE_COUNT:   n_cfg     <= cfg_data[6:0];
          CFG_COMBINATION_LENGTH: len_cfg   <= cfg_data[3:0];
          CFG_CUMULATIVE_BOUND:   cum_bound <= cfg_data;
          CFG_PRECURSOR_BOUND:    pre_bound <= cfg_data;
          default:                n_cfg     <= n_cfg;
        endcase
      end
      case (cmd.op)
        OP_CLEAR: begin
          cnt_vld <= '0;
          for (int i = 0; i < MAX_SLOTS; i++) begin
            slot[i] <= '0;
          end
        end
        OP_START: begin
          nb     <= n_sat;
          slen   <= len_sat;
          p      <= '0;
          swk    <= '0;
          s_mass <= '0;
        end
        OP_SWACC: begin
          s_mass <= s_mass + MW'(prod);
          swk    <= swk + CW'(1);
        end
        OP_LDX: x <= sv;
        OP_DEC: begin
          if (rng_q) begin
            cnt_vld[wr_addr] <= 1'b1;
            s_mass <= (cnt_eff == '0) ? s_mass + m15 : s_mass - m1;
          end
        end
        OP_INC: begin
          if (rng_q) begin
            cnt_vld[wr_addr] <= 1'b1;
            s_mass <= (cnt_eff == '1) ? s_mass - m15 : s_mass + m1;
          end
        end
        OP_BUMPW: begin
          x                  <= bx;
          slot[sidx[SIW-1:0]] <= bx;
        end
        OP_BUMPX: x <= bx;
        OP_SATW: begin
          x                  <= nb + SW'(1);
          slot[sidx[SIW-1:0]] <= nb + SW'(1);
        end
        OP_VW:     slot[sidx[SIW-1:0]] <= x;
        OP_PREV:   prev <= x;
        OP_PINC:   p <= p + PW'(1);
        OP_JP:     j <= p;
        OP_JDEC:   j <= j - PW'(1);
        OP_FOUND1: begin
          found <= 1'b1;
          k     <= '0;
        end
        OP_FOUND0: begin
          found <= 1'b0;
          k     <= '0;
        end
        OP_KINC:   k <= k + PW'(1);
        default:   x <= x;
      endcase
    end
  end

  // Status back to the controller
  always_comb begin
    status.sv_le_nb   = sv <= nb;
    status.over       = ((cum_bound != '0) && (s_mass > MW'(cum_bound))) ||
                        ((pre_bound != '0) && (s_mass > MW'(pre_bound)));
    status.lh         = rng_q && (lim_q != '0) && (cnt_eff > lim_q);
    status.rf         = rng_q && (lim_q != '0) &&
                        ((COUNT_W+1)'(cnt_eff) + (COUNT_W+1)'(1) > (COUNT_W+1)'(lim_q));
    status.slot0_gt   = slot[0] > nb;
    status.p_lt_last  = (PW+1)'(p) + (PW+1)'(1) < (PW+1)'(slen);
    status.p_lt_len   = p < slen;
    status.cmp_prev   = (SW+1)'(sv) + (SW+1)'(1) >= (SW+1)'(prev);
    status.j_zero     = j == '0;
    status.sweep_done = SW'(swk) == nb;
    status.k_last     = (PW+1)'(k) + (PW+1)'(1) == (PW+1)'(slen);
  end

  // Result of the slot under the output pointer
  always_comb begin
    out_item.found            = found;
    out_item.combination_mass = (s_mass[MW-1:MASS_W] != '0) ? '1 : s_mass[MASS_W-1:0];
    out_item.slot_position    = SLOT_POS_W'(k);
    out_item.slot_value       = SLOT_VALUE_W'(sv);
    out_item.last             = status.k_last;
  end

endmodule
`default_nettype wire

// File: src/mbce_ctrl.sv
// Sequencer of the combination enumerator: walks the odometer advance as a
// series of datapath operations. Depends on mbce_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mbce_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [mbce_pkg::FUNC_W-1:0]    in_func,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  input  mbce_pkg::status_t              status,
  output mbce_pkg::cmd_t                 cmd
);
  import mbce_pkg::*;

  typedef enum logic [5:0] {
    IDLE, SWP_RD, SWP_ACC,
    IS_LD, IS_RD1, IS_DEC, IS_BUMP, IS_RD2, IS_INC, IS_RD3,
    A_CHK, OV_PREV, OV_LDX, OV_RD, OV_DEC, OV_SAT, OV_LOOP, LM_CHK,
    A_POST, A_NEXT,
    RF_INIT, RF_TEST, RF_LD, RF_RD1, RF_DEC, RF_LDV, RF_RDV, RF_WH,
    RF_RD2, RF_INC, RF_JD,
    C_LD, C_RD, C_EV, OUT
  } state_t;

  state_t state, state_next;
  state_t ret, ret_next;
  logic   carried, carried_next;
  logic   bad;

  assign in_stall  = state != IDLE;
  assign out_valid = state == OUT;
  assign bad       = status.over || status.lh || status.slot0_gt;

  // Pick the operation and the next step
  always_comb begin
    state_next   = state;
    ret_next     = ret;
    carried_next = carried;
    cmd.op       = OP_NONE;
    cmd.sel      = SEL_P;
    case (state)
      IDLE: begin
        if (in_valid) begin
          case (in_func)
            FUNC_LOAD:  cmd.op = OP_LOAD;
            FUNC_CLEAR: cmd.op = OP_CLEAR;
            FUNC_ADVANCE: begin
              cmd.op       = OP_START;
              carried_next = 1'b0;
              state_next   = SWP_RD;
            end
            default:    cmd.op = OP_NONE;
          endcase
        end
      end
      // Re-sum the mass over all block counts
      SWP_RD: begin
        if (status.sweep_done) begin
          ret_next   = A_CHK;
          state_next = IS_LD;
        end else begin
          cmd.op     = OP_SWRD;
          state_next = SWP_ACC;
        end
      end
      SWP_ACC: begin
        cmd.op     = OP_SWACC;
        state_next = SWP_RD;
      end
      // Increment slot p, keeping counts and mass in step
      IS_LD:   begin cmd.op = OP_LDX;   state_next = IS_RD1;  end
      IS_RD1:  begin cmd.op = OP_RD;    state_next = IS_DEC;  end
      IS_DEC:  begin cmd.op = OP_DEC;   state_next = IS_BUMP; end
      IS_BUMP: begin cmd.op = OP_BUMPW; state_next = IS_RD2;  end
      IS_RD2:  begin cmd.op = OP_RD;    state_next = IS_INC;  end
      IS_INC:  begin cmd.op = OP_INC;   state_next = IS_RD3;  end
      IS_RD3:  begin cmd.op = OP_RD;    state_next = ret;     end
      A_CHK: begin
        if (!carried && status.sv_le_nb && (status.over || status.lh)) begin
          state_next = status.over ? OV_PREV : LM_CHK;
        end else begin
          state_next = A_POST;
        end
      end
      // Over the bound: exhaust this slot and the ones that follow it
      OV_PREV: begin cmd.op = OP_PREV; state_next = OV_RD;  end
      OV_LDX:  begin cmd.op = OP_LDX;  state_next = OV_RD;  end
      OV_RD:   begin cmd.op = OP_RD;   state_next = OV_DEC; end
      OV_DEC:  begin cmd.op = OP_DEC;  state_next = OV_SAT; end
      OV_SAT:  begin cmd.op = OP_SATW; state_next = OV_LOOP; end
      OV_LOOP: begin
        cmd.sel = SEL_P1;
        if (status.p_lt_last && status.cmp_prev) begin
          cmd.op     = OP_PINC;
          state_next = OV_LDX;
        end else begin
          state_next = A_POST;
        end
      end
      // Over a block limit: keep stepping the slot
      LM_CHK: begin
        if (status.sv_le_nb && status.lh) begin
          ret_next   = LM_CHK;
          state_next = IS_LD;
        end else begin
          state_next = A_POST;
        end
      end
      A_POST: begin
        if (status.sv_le_nb) begin
          if (carried) begin
            state_next = RF_INIT;
          end else begin
            cmd.op     = OP_FOUND1;
            state_next = OUT;
          end
        end else begin
          cmd.op       = OP_PINC;
          carried_next = 1'b1;
          state_next   = A_NEXT;
        end
      end
      A_NEXT: begin
        if (status.p_lt_len) begin
          ret_next   = A_CHK;
          state_next = IS_LD;
        end else begin
          cmd.op     = OP_FOUND0;
          state_next = OUT;
        end
      end
      // Refill the lower slots from the one above, downward
      RF_INIT: begin cmd.op = OP_JP; state_next = RF_TEST; end
      RF_TEST: state_next = status.j_zero ? C_LD : RF_LD;
      RF_LD:   begin cmd.op = OP_LDX; cmd.sel = SEL_J1; state_next = RF_RD1; end
      RF_RD1:  begin cmd.op = OP_RD;  state_next = RF_DEC; end
      RF_DEC:  begin cmd.op = OP_DEC; state_next = RF_LDV; end
      RF_LDV:  begin cmd.op = OP_LDX; cmd.sel = SEL_J; state_next = RF_RDV; end
      RF_RDV:  begin cmd.op = OP_RD;  state_next = RF_WH; end
      RF_WH: begin
        if (status.rf) begin
          cmd.op     = OP_BUMPX;
          state_next = RF_RDV;
        end else begin
          cmd.op     = OP_VW;
          cmd.sel    = SEL_J1;
          state_next = RF_RD2;
        end
      end
      RF_RD2:  begin cmd.op = OP_RD;   state_next = RF_INC;  end
      RF_INC:  begin cmd.op = OP_INC;  state_next = RF_JD;   end
      RF_JD:   begin cmd.op = OP_JDEC; state_next = RF_TEST; end
      // Check the carried slot after the refill
      C_LD:    begin cmd.op = OP_LDX; state_next = C_RD; end
      C_RD:    begin cmd.op = OP_RD;  state_next = C_EV; end
      C_EV: begin
        if (status.sv_le_nb && status.p_lt_last && bad) begin
          cmd.op     = OP_PINC;
          ret_next   = RF_INIT;
          state_next = IS_LD;
        end else if (!status.sv_le_nb || bad) begin
          cmd.op     = OP_FOUND0;
          state_next = OUT;
        end else begin
          cmd.op     = OP_FOUND1;
          state_next = OUT;
        end
      end
      // Hand out one transaction per slot
      OUT: begin
        cmd.sel = SEL_K;
        if (!out_stall) begin
          if (status.k_last) begin
            state_next = IDLE;
          end else begin
            cmd.op = OP_KINC;
          end
        end
      end
      default: state_next = IDLE;
    endcase
  end

  // Hold state and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      ret     <= IDLE;
      carried <= 1'b0;
    end else begin
      state   <= state_next;
      ret     <= ret_next;
      carried <= carried_next;
    end
  end

endmodule
`default_nettype wire

// File: src/mass_bounded_combination_enumerator_unit.sv
// Bounded multiset combination enumerator. Load, clear and unused-function
// transactions are handled in the idle state and give no result. An advance
// first re-sums the mass over the n block counts, with a read step and an
// accumulate step per block, then steps and refills slots, skipping blocks at
// their limit, all through single-ported block and count memories, and
// finally hands out L result transactions, one per cycle when not stalled.
// Carries, refills and skips lengthen an advance.
// Input is stalled from the accepted advance until its last result.
// Depends on mbce_pkg, mbce_ctrl, mbce_datapath and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mass_bounded_combination_enumerator_unit_macros.svh"
module mass_bounded_combination_enumerator_unit #(
  parameter int MAX_BLOCK_TYPES = 64,
  parameter int MAX_SLOTS       = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  mbce_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_stall,
  output mbce_pkg::out_item_t               out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mbce_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mbce_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mbce_pkg::*;

  cmd_t    cmd;
  status_t status;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  mbce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (in_item.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mbce_datapath #(
    .MAX_BLOCK_TYPES (MAX_BLOCK_TYPES),
    .MAX_SLOTS       (MAX_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_item  (out_item)
  );

  // No input is taken while results are being handed out
  `MBCE_ASSERT_IMM(a_stall_during_output, out_valid, in_stall)
  // The final slot ends the burst of results
  `MBCE_ASSERT_NEXT(a_last_ends_burst, out_valid && !out_stall && out_item.last, !out_valid)
  // An accepted advance keeps the input stalled while it runs
  `MBCE_ASSERT_NEXT(a_advance_busy, in_valid && !in_stall && in_item.func == FUNC_ADVANCE, in_stall)

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking testbench for mass_bounded_combination_enumerator_unit.
// Holds its own odometer-style enumerator predictor; depends on mbce_pkg and the unit.
`timescale 1ns / 1ps
module tb;
  import mbce_pkg::*;

  localparam int NBLK = 64;
  localparam int NSLOT = 8;
  localparam int STALL_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mass_bounded_combination_enumerator_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: registers, slots, counts and the block table
  logic [6:0] reg_count = 7'd1;
  logic [3:0] reg_length = 4'd1;
  logic [31:0] reg_cum_bound = '0;
  logic [31:0] reg_pre_bound = '0;
  int unsigned slots[NSLOT];
  logic [3:0] use_cnt[NBLK];
  logic [31:0] blk_mass[NBLK];
  logic [3:0] blk_lim[NBLK];
  int unsigned eff_n;
  int eff_len;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  int n_adv = 0, n_results = 0, n_found = 0, n_items = 0;

  // Append one transaction to the pending queue
  function automatic void queue_item(in_item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic bit in_use(int unsigned v);
    return v >= 1 && v <= eff_n;
  endfunction

  function automatic void drop_use(int unsigned v);
    if (in_use(v)) use_cnt[v-1] = use_cnt[v-1] - 4'd1;
  endfunction

  function automatic void add_use(int unsigned v);
    if (in_use(v)) use_cnt[v-1] = use_cnt[v-1] + 4'd1;
  endfunction

  function automatic int unsigned step_up(int unsigned v);
    return (v >= eff_n) ? eff_n + 1 : v + 1;
  endfunction

  function automatic longint unsigned sum_mass();
    longint unsigned s;
    s = 0;
    for (int i = 0; i < eff_n; i++)
      s += longint'(use_cnt[i]) * longint'(blk_mass[i]);
    return s;
  endfunction

  function automatic bit exceeds(longint unsigned m);
    return (reg_cum_bound != 0 && m > longint'(reg_cum_bound)) ||
           (reg_pre_bound != 0 && m > longint'(reg_pre_bound));
  endfunction

  function automatic bit over_limit(int unsigned v);
    return in_use(v) && blk_lim[v-1] != 0 && use_cnt[v-1] > blk_lim[v-1];
  endfunction

  function automatic void bump_slot(int p);
    drop_use(slots[p]);
    slots[p] = step_up(slots[p]);
    add_use(slots[p]);
  endfunction

  // copy the next slot down, skipping blocks already at their limit
  function automatic void refill_slot(int i);
    int unsigned v;
    drop_use(slots[i]);
    v = slots[i+1];
    while (in_use(v) && blk_lim[v-1] != 0 && int'(use_cnt[v-1]) + 1 > int'(blk_lim[v-1]))
      v = step_up(v);
    slots[i] = v;
    add_use(v);
  endfunction

  function automatic bit next_combination(output longint unsigned m);
    int p;
    int prev;
    bit carried;
    p = 0;
    carried = 0;
    m = 0;
    do begin
      bump_slot(p);
      m = sum_mass();
      if (!carried && slots[p] <= eff_n && (exceeds(m) || over_limit(slots[p]))) begin
        if (exceeds(m)) begin
          prev = int'(slots[p]);
          drop_use(slots[p]);
          slots[p] = eff_n + 1;
          while (p + 1 < eff_len && int'(slots[p+1]) >= prev - 1) begin
            p++;
            drop_use(slots[p]);
            slots[p] = eff_n + 1;
          end
        end else begin
          while (slots[p] <= eff_n && over_limit(slots[p])) bump_slot(p);
        end
        m = sum_mass();
      end
      if (slots[p] <= eff_n) begin
        if (carried) begin
          for (int i = p - 1; i >= 0; i--) refill_slot(i);
          m = sum_mass();
          while (slots[p] <= eff_n && p < eff_len - 1 &&
                 (exceeds(m) || over_limit(slots[p]) || slots[0] > eff_n)) begin
            p++;
            bump_slot(p);
            for (int i = p - 1; i >= 0; i--) refill_slot(i);
            m = sum_mass();
          end
          if (slots[p] > eff_n || exceeds(m) || over_limit(slots[p]) || slots[0] > eff_n)
            return 1'b0;
        end
        return 1'b1;
      end
      carried = 1'b1;
      p++;
    end while (p < eff_len);
    return 1'b0;
  endfunction

  // Apply one accepted transaction and queue the results it causes
  function automatic void predict_item(in_item_t it);
    longint unsigned m;
    bit ok;
    out_item_t r;
    case (it.func)
      FUNC_LOAD: begin
        blk_mass[it.block_index] = it.block_mass;
        blk_lim[it.block_index] = it.block_limit;
      end
      FUNC_CLEAR: begin
        foreach (slots[i]) slots[i] = 0;
        foreach (use_cnt[i]) use_cnt[i] = '0;
      end
      FUNC_ADVANCE: begin
        eff_n = (reg_count < 1) ? 1 : (reg_count > NBLK) ? NBLK : reg_count;
        eff_len = (reg_length < 1) ? 1 : (reg_length > NSLOT) ? NSLOT : reg_length;
        ok = next_combination(m);
        if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
        n_adv++;
        if (ok) n_found++;
        for (int k = 0; k < eff_len; k++) begin
          r.found = ok;
          r.combination_mass = m[31:0];
          r.slot_position = k[2:0];
          r.slot_value = slots[k][6:0];
          r.last = (k == eff_len - 1);
          expected_results.insert(expected_results.size(), r);
        end
      end
      default: ;
    endcase
  endfunction

  // Driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic fire;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      fire = in_valid && !in_stall;
      if (fire) begin
        predict_item(in_item);
        n_items++;
      end
      if (!in_valid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_item <= pending_items.pop_front();
          if (burst_left == 0) begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transaction against the oldest expectation
  int stall_phase = 0;
  int quiet_cycles = 0;
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: got %p", $time, out_item);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r !== out_item) begin
            errors++;
            $display("%0t: result mismatch: expected %p actual %p", $time, exp_r, out_item);
          end
        end
      end
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
    // stall pattern cycles through none, light, heavy and periodic in turn
    stall_phase = stall_phase + 1;
    case ((stall_phase / 50) % 4)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_phase % 3 == 0);
    endcase
  end

  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [31:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BLOCK_TYPE_COUNT: reg_count = d[6:0];
      CFG_COMBINATION_LENGTH: reg_length = d[3:0];
      CFG_CUMULATIVE_BOUND: reg_cum_bound = d;
      default: reg_pre_bound = d;
    endcase
  endtask

  task automatic set_config(input logic [6:0] n, input logic [3:0] len,
                            input logic [31:0] b1, input logic [31:0] b2);
    cfg_write(CFG_BLOCK_TYPE_COUNT, {25'd0, n});
    cfg_write(CFG_COMBINATION_LENGTH, {28'd0, len});
    cfg_write(CFG_CUMULATIVE_BOUND, b1);
    cfg_write(CFG_PRECURSOR_BOUND, b2);
  endtask

  // Wait until all queued transactions are in and all results are out
  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic in_item_t mk(logic [1:0] f, logic [5:0] idx = 0,
                                  logic [31:0] ms = 0, logic [3:0] lim = 0);
    in_item_t it;
    it.func = f;
    it.block_index = idx;
    it.block_mass = ms;
    it.block_limit = lim;
    return it;
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0001_0000, 32'h00C8_0000);
    endcase
  endfunction

  function automatic logic [31:0] rand_bound(int len);
    case ($urandom_range(0, 5))
      0, 1: return 0;
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'h0001_0000, (len * 150) << 16);
    endcase
  endfunction

  initial begin
    int n, len, nitems, r;
    foreach (slots[i]) slots[i] = 0;
    foreach (use_cnt[i]) use_cnt[i] = '0;
    foreach (blk_mass[i]) blk_mass[i] = '0;
    foreach (blk_lim[i]) blk_lim[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // fill the whole block table first so no advance reads an unloaded entry
    for (int i = 0; i < NBLK; i++)
      queue_item(mk(FUNC_LOAD, i[5:0], rand_mass(), 4'($urandom_range(0, 3))));
    queue_item(mk(FUNC_LOAD, 6'd0, 32'h0005_0000, 4'd0));
    queue_item(mk(FUNC_LOAD, 6'd1, 32'h0003_0000, 4'd1));
    queue_item(mk(FUNC_LOAD, 6'd2, 32'h0002_0000, 4'd0));
    drain();

    // directed: full walk to exhaustion, then advances past the end
    set_config(7'd3, 4'd3, 32'd0, 32'd0);
    queue_item(mk(FUNC_CLEAR));
    repeat (10) queue_item(mk(FUNC_ADVANCE));
    queue_item(mk(2'd3, 6'h3F, 32'hFFFF_FFFF, 4'hF));
    queue_item(mk(FUNC_ADVANCE));
    drain();

    // directed: both bounds active, tight
    set_config(7'd3, 4'd3, 32'h000C_0000, 32'h000A_0000);
    queue_item(mk(FUNC_CLEAR));
    repeat (5) queue_item(mk(FUNC_ADVANCE));
    drain();

    // directed: saturating mass, limits of eight and fifteen
    set_config(7'd2, 4'd8, 32'hFFFF_FFFF, 32'd0);
    queue_item(mk(FUNC_LOAD, 6'd0, 32'hFFFF_FFFF, 4'd8));
    queue_item(mk(FUNC_LOAD, 6'd1, 32'hFFFF_FFFF, 4'hF));
    queue_item(mk(FUNC_CLEAR));
    repeat (3) queue_item(mk(FUNC_ADVANCE));
    drain();

    // directed: out-of-range registers, no clear in between
    set_config(7'd0, 4'd0, 32'd0, 32'hFFFF_FFFF);
    repeat (2) queue_item(mk(FUNC_ADVANCE));
    drain();
    set_config(7'd127, 4'd15, 32'd0, 32'd0);
    repeat (2) queue_item(mk(FUNC_ADVANCE));
    drain();

    // random phases: mostly a clear followed by a run of mostly advances
    while (n_items < 390) begin
      r = $urandom_range(0, 9);
      n = (r == 0) ? $urandom_range(0, 127) : (r < 3) ? $urandom_range(8, 64)
                                                      : $urandom_range(1, 6);
      len = (r == 9) ? $urandom_range(0, 15) : $urandom_range(1, 5);
      set_config(n[6:0], len[3:0], rand_bound(len), rand_bound(len));
      if ($urandom_range(0, 3) != 0) queue_item(mk(FUNC_CLEAR));
      nitems = $urandom_range(15, 40);
      for (int k = 0; k < nitems; k++) begin
        r = $urandom_range(0, 99);
        if (r < 78) queue_item(mk(FUNC_ADVANCE, 6'($urandom()), 32'($urandom())));
        else if (r < 86)
          queue_item(mk(FUNC_LOAD, 6'($urandom_range(0, 63)), rand_mass(),
                        ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                    : 4'($urandom_range(0, 8))));
        else if (r < 93) queue_item(mk(FUNC_CLEAR, 6'($urandom()), 32'($urandom())));
        else queue_item(mk(2'd3, 6'($urandom()), 32'($urandom()), 4'($urandom())));
      end
      drain();
    end

    $display("Covered %0d transactions, %0d advances (%0d found a combination), %0d results.",
             n_items, n_adv, n_found, n_results);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
